FILE: hw/rtl/owrb_pkg.sv
// package for the offset window ring buffer
// widths, command codes, register map and controller/datapath structs
`default_nettype none

package owrb_pkg;

    localparam int OFFSET_W     = 32;
    localparam int CAP_W        = 13;
    localparam int SIZE_W       = 7;
    localparam int BYTE_W       = 8;
    localparam int APB_AW       = 2;
    localparam int APB_DW       = 32;

    localparam int DEPTH_DEF    = 4096;
    localparam int MAX_READ_DEF = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

    // quotient bits resolved per cycle in the modulo unit
    localparam int MOD_STEPS    = 4;

    localparam logic [1:0] CMD_APPEND  = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_CONSUME = 2'd2;
    localparam logic [1:0] CMD_REWIND  = 2'd3;

    localparam logic [APB_AW-1:0] ADDR_CAP = 2'd0;

    typedef struct packed {
        logic load;
        logic emit_single;
        logic ok;
        logic append;
        logic consume;
        logic rewind;
        logic mod_go;
        logic mod_end;
        logic load_idx;
        logic set_end_idx;
        logic emit_byte;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       read_zero;
        logic       read_fail;
        logic       full;
        logic       mod_done;
        logic       last_byte;
        logic       cap_dirty;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: hw/rtl/offset_window_ring_buffer.sv
// offset window ring buffer: append, consume, rewind and rejected or empty reads give one
// result each, and a new item is taken only while busy is low; a read of n bytes first waits
// on the 32-bit modulo unit (4 bits a cycle) for its start index, then gives one byte per
// cycle; a capacity write keeps busy high while the end index is remapped; synchronous
// active-low reset clears offsets to zero and capacity to 4096; store contents are
// undefined until written; results cannot be stalled
`default_nettype none

module offset_window_ring_buffer #(
    parameter int DEPTH    = owrb_pkg::DEPTH_DEF,
    parameter int MAX_READ = owrb_pkg::MAX_READ_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [owrb_pkg::APB_AW-1:0]   paddr,
    input  wire logic [owrb_pkg::APB_DW-1:0]   pwdata,
    output logic [owrb_pkg::APB_DW-1:0]        prdata,
    output logic                               pready,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_cmd,
    input  wire logic [owrb_pkg::OFFSET_W-1:0] i_offset,
    input  wire logic [owrb_pkg::SIZE_W-1:0]   i_size,
    input  wire logic [owrb_pkg::BYTE_W-1:0]   i_write_byte,
    output logic                               o_valid,
    output logic                               o_ok,
    output logic [owrb_pkg::BYTE_W-1:0]        o_read_byte,
    output logic                               o_last,
    output logic [owrb_pkg::OFFSET_W-1:0]      o_window_start,
    output logic [owrb_pkg::OFFSET_W-1:0]      o_window_end,
    output logic [owrb_pkg::CAP_W-1:0]         o_available,
    output logic [owrb_pkg::CAP_W-1:0]         o_contiguous_free
);
    import owrb_pkg::*;

    t_dp_cmd  dcmd;
    t_dp_stat stat;

    assign pready = 1'b1;

    owrb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (dcmd)
    );

    owrb_dp #(
        .DEPTH    (DEPTH),
        .MAX_READ (MAX_READ)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .i_cmd             (i_cmd),
        .i_offset          (i_offset),
        .i_size            (i_size),
        .i_write_byte      (i_write_byte),
        .i_dcmd            (dcmd),
        .o_stat            (stat),
        .o_valid           (o_valid),
        .o_ok              (o_ok),
        .o_read_byte       (o_read_byte),
        .o_last            (o_last),
        .o_window_start    (o_window_start),
        .o_window_end      (o_window_end),
        .o_available       (o_available),
        .o_contiguous_free (o_contiguous_free)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/owrb_mod.sv
// iterative remainder unit, several quotient bits per cycle
// uses owrb_pkg for the dividend width and step count
`default_nettype none

module owrb_mod #(
    parameter int DW = 13
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_go,
    input  wire logic [owrb_pkg::OFFSET_W-1:0] i_dividend,
    input  wire logic [DW-1:0]                 i_divisor,
    output logic                               o_done,
    output logic [DW-1:0]                      o_rem
);
    import owrb_pkg::*;

    localparam int CYC = OFFSET_W / MOD_STEPS;
    localparam int CW  = $clog2(CYC + 1);

    logic                r_busy;
    logic                r_done;
    logic [CW-1:0]       r_cnt;
    logic [DW-1:0]       r_rem;
    logic [OFFSET_W-1:0] r_quo;
    logic [DW-1:0]       n_rem;
    logic [OFFSET_W-1:0] n_quo;

    always_comb begin
        logic [DW:0] t;
        n_rem = r_rem;
        n_quo = r_quo;
        t     = '0;
        for (int i = 0; i < MOD_STEPS; i++) begin
            t     = {n_rem, n_quo[OFFSET_W-1]};
            n_quo = {n_quo[OFFSET_W-2:0], 1'b0};
            if (t >= {1'b0, i_divisor}) begin
                t = t - {1'b0, i_divisor};
            end
            n_rem = t[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(CYC);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

FILE: hw/rtl/owrb_ctrl.sv
// command sequencer for the offset window ring buffer
// drives owrb_dp through owrb_pkg::t_dp_cmd, reads t_dp_stat
`default_nettype none

module owrb_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire owrb_pkg::t_dp_stat i_stat,
    output owrb_pkg::t_dp_cmd       o_cmd
);
    import owrb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_RDMOD = 5'b00100,
        S_RDOUT = 5'b01000,
        S_REMAP = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_stat.cap_dirty) begin
                    o_cmd.mod_go  = 1'b1;
                    o_cmd.mod_end = 1'b1;
                    n_state       = S_REMAP;
                end else if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (i_stat.cmd)
                    CMD_APPEND: begin
                        o_cmd.emit_single = 1'b1;
                        o_cmd.ok          = !i_stat.full;
                        o_cmd.append      = !i_stat.full;
                    end
                    CMD_READ: begin
                        priority if (i_stat.read_zero) begin
                            o_cmd.emit_single = 1'b1;
                            o_cmd.ok          = 1'b1;
                        end else if (i_stat.read_fail) begin
                            o_cmd.emit_single = 1'b1;
                            o_cmd.ok          = 1'b0;
                        end else begin
                            o_cmd.mod_go = 1'b1;
                            n_state      = S_RDMOD;
                        end
                    end
                    CMD_CONSUME: begin
                        o_cmd.emit_single = 1'b1;
                        o_cmd.ok          = 1'b1;
                        o_cmd.consume     = 1'b1;
                    end
                    CMD_REWIND: begin
                        o_cmd.emit_single = 1'b1;
                        o_cmd.ok          = 1'b1;
                        o_cmd.rewind      = 1'b1;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_RDMOD: begin
                if (i_stat.mod_done) begin
                    o_cmd.load_idx = 1'b1;
                    n_state        = S_RDOUT;
                end
            end
            S_RDOUT: begin
                o_cmd.emit_byte = 1'b1;
                if (i_stat.last_byte) begin
                    n_state = S_IDLE;
                end
            end
            S_REMAP: begin
                if (i_stat.mod_done) begin
                    o_cmd.set_end_idx = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE) || i_stat.cap_dirty;

endmodule

`default_nettype wire

FILE: hw/rtl/owrb_dp.sv
// datapath: byte store, window offsets, capacity register, result registers
// uses owrb_pkg and instantiates owrb_mod
`default_nettype none

module owrb_dp #(
    parameter int DEPTH    = owrb_pkg::DEPTH_DEF,
    parameter int MAX_READ = owrb_pkg::MAX_READ_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [owrb_pkg::APB_AW-1:0]   paddr,
    input  wire logic [owrb_pkg::APB_DW-1:0]   pwdata,
    output logic [owrb_pkg::APB_DW-1:0]        prdata,
    input  wire logic [1:0]                    i_cmd,
    input  wire logic [owrb_pkg::OFFSET_W-1:0] i_offset,
    input  wire logic [owrb_pkg::SIZE_W-1:0]   i_size,
    input  wire logic [owrb_pkg::BYTE_W-1:0]   i_write_byte,
    input  wire owrb_pkg::t_dp_cmd             i_dcmd,
    output owrb_pkg::t_dp_stat                 o_stat,
    output logic                               o_valid,
    output logic                               o_ok,
    output logic [owrb_pkg::BYTE_W-1:0]        o_read_byte,
    output logic                               o_last,
    output logic [owrb_pkg::OFFSET_W-1:0]      o_window_start,
    output logic [owrb_pkg::OFFSET_W-1:0]      o_window_end,
    output logic [owrb_pkg::CAP_W-1:0]         o_available,
    output logic [owrb_pkg::CAP_W-1:0]         o_contiguous_free
);
    import owrb_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int IW   = $clog2(DEPTH + 1);
    localparam int CNTW = $clog2(MAX_READ + 1);

    logic [BYTE_W-1:0]   r_mem [DEPTH];
    logic [BYTE_W-1:0]   r_mem_q;

    logic [CAP_W-1:0]    r_cap_reg;
    logic                r_cap_dirty;

    logic [1:0]          r_cmd;
    logic [OFFSET_W-1:0] r_off;
    logic [SIZE_W-1:0]   r_size;
    logic [BYTE_W-1:0]   r_wbyte;

    logic [OFFSET_W-1:0] r_base;
    logic [OFFSET_W-1:0] r_end;
    logic [OFFSET_W-1:0] r_start;
    logic [AW-1:0]       r_end_idx;
    logic [AW-1:0]       r_idx;
    logic [CNTW-1:0]     r_cnt;

    logic                r_valid;
    logic                r_ok;
    logic                r_last;
    logic                r_byte_sel;

    logic                cfg_wr;
    logic [OFFSET_W-1:0] cap_ext;
    logic [OFFSET_W-1:0] cap_clamp;
    logic [IW-1:0]       cap;
    logic [OFFSET_W-1:0] held;
    logic                full;
    logic [IW-1:0]       free_cnt;
    logic [IW-1:0]       to_end;
    logic [IW-1:0]       contig;
    logic [OFFSET_W-1:0] contig_ext;
    logic [AW-1:0]       end_idx_inc;
    logic [AW-1:0]       idx_inc;
    logic [OFFSET_W-1:0] mod_dividend;
    logic                mod_done;
    logic [IW-1:0]       mod_rem;

    // configuration port
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_CAP);
    assign prdata = APB_DW'(r_cap_reg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_reg   <= CAP_RESET;
            r_cap_dirty <= 1'b0;
        end else if (cfg_wr) begin
            r_cap_reg   <= pwdata[CAP_W-1:0];
            r_cap_dirty <= 1'b1;
        end else if (i_dcmd.mod_go && i_dcmd.mod_end) begin
            r_cap_dirty <= 1'b0;
        end
    end

    // effective capacity, clamped to 1..DEPTH
    assign cap_ext   = OFFSET_W'(r_cap_reg);
    assign cap_clamp = (cap_ext == '0) ? OFFSET_W'(1) :
                       (cap_ext > OFFSET_W'(DEPTH)) ? OFFSET_W'(DEPTH) : cap_ext;
    assign cap       = cap_clamp[IW-1:0];

    assign held     = r_end - r_start;
    assign full     = held >= OFFSET_W'(cap);
    assign free_cnt = full ? '0 : (cap - held[IW-1:0]);
    assign to_end   = cap - IW'(r_end_idx);
    assign contig   = (free_cnt < to_end) ? free_cnt : to_end;
    assign contig_ext = OFFSET_W'(contig);

    assign end_idx_inc = ((IW'(r_end_idx) + 1'b1) == cap) ? '0 : (r_end_idx + 1'b1);
    assign idx_inc     = ((IW'(r_idx) + 1'b1) == cap) ? '0 : (r_idx + 1'b1);

    assign mod_dividend = i_dcmd.mod_end ? (r_end - r_base) : (r_off - r_base);

    owrb_mod #(
        .DW(IW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_dcmd.mod_go),
        .i_dividend (mod_dividend),
        .i_divisor  (cap),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_dcmd.load) begin
            r_cmd   <= i_cmd;
            r_off   <= i_offset;
            r_size  <= i_size;
            r_wbyte <= i_write_byte;
        end
    end

    // window offsets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= '0;
            r_end     <= '0;
            r_start   <= '0;
            r_end_idx <= '0;
        end else begin
            if (i_dcmd.append) begin
                r_end     <= r_end + 1'b1;
                r_end_idx <= end_idx_inc;
            end
            if (i_dcmd.consume && (r_off > r_start)) begin
                r_start <= (r_off > r_end) ? r_end : r_off;
            end
            if (i_dcmd.rewind) begin
                r_base    <= r_off;
                r_end     <= r_off;
                r_start   <= r_off;
                r_end_idx <= '0;
            end
            if (i_dcmd.set_end_idx) begin
                r_end_idx <= mod_rem[AW-1:0];
            end
        end
    end

    // byte store
    always_ff @(posedge i_clk) begin
        if (i_dcmd.append) begin
            r_mem[r_end_idx] <= r_wbyte;
        end
        if (i_dcmd.emit_byte) begin
            r_mem_q <= r_mem[r_idx];
        end
    end

    // read span walk
    always_ff @(posedge i_clk) begin
        if (i_dcmd.load_idx) begin
            r_idx <= mod_rem[AW-1:0];
            r_cnt <= CNTW'(r_size);
        end else if (i_dcmd.emit_byte) begin
            r_idx <= idx_inc;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_dcmd.emit_single || i_dcmd.emit_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dcmd.emit_single || i_dcmd.emit_byte) begin
            r_ok       <= i_dcmd.emit_single ? i_dcmd.ok : 1'b1;
            r_last     <= i_dcmd.emit_single || (r_cnt == CNTW'(1));
            r_byte_sel <= i_dcmd.emit_byte;
        end
    end

    // status to the sequencer
    assign o_stat.cmd       = r_cmd;
    assign o_stat.read_zero = (r_size == '0);
    assign o_stat.read_fail = (OFFSET_W'(r_size) > OFFSET_W'(MAX_READ)) ||
                              (OFFSET_W'(r_size) > OFFSET_W'(cap)) ||
                              (r_off < r_start) || (r_off > r_end) ||
                              ((r_end - r_off) < OFFSET_W'(r_size));
    assign o_stat.full      = full;
    assign o_stat.mod_done  = mod_done;
    assign o_stat.last_byte = (r_cnt == CNTW'(1));
    assign o_stat.cap_dirty = r_cap_dirty;

    assign o_valid           = r_valid;
    assign o_ok              = r_ok;
    assign o_read_byte       = r_byte_sel ? r_mem_q : '0;
    assign o_last            = r_last;
    assign o_window_start    = r_start;
    assign o_window_end      = r_end;
    assign o_available       = held[CAP_W-1:0];
    assign o_contiguous_free = contig_ext[CAP_W-1:0];

endmodule

`default_nettype wire

FILE: bench/owrb_checker.sv
`timescale 1ns / 1ps
// window checker for the offset window ring buffer: watches the apb and item channels,
// predicts every result from its own copy of the window and store, and counts mismatches
// depends on owrb_pkg for widths, command codes and the register map

module owrb_checker #(
    parameter int DEPTH    = owrb_pkg::DEPTH_DEF,
    parameter int MAX_READ = owrb_pkg::MAX_READ_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic                          i_pready,
    input  wire logic [owrb_pkg::APB_AW-1:0]   i_paddr,
    input  wire logic [owrb_pkg::APB_DW-1:0]   i_pwdata,
    input  wire logic                          i_start,
    input  wire logic                          i_busy,
    input  wire logic [1:0]                    i_cmd,
    input  wire logic [owrb_pkg::OFFSET_W-1:0] i_offset,
    input  wire logic [owrb_pkg::SIZE_W-1:0]   i_size,
    input  wire logic [owrb_pkg::BYTE_W-1:0]   i_write_byte,
    input  wire logic                          i_valid,
    input  wire logic                          i_ok,
    input  wire logic [owrb_pkg::BYTE_W-1:0]   i_read_byte,
    input  wire logic                          i_last,
    input  wire logic [owrb_pkg::OFFSET_W-1:0] i_window_start,
    input  wire logic [owrb_pkg::OFFSET_W-1:0] i_window_end,
    input  wire logic [owrb_pkg::CAP_W-1:0]    i_available,
    input  wire logic [owrb_pkg::CAP_W-1:0]    i_contiguous_free,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import owrb_pkg::*;

    localparam int AW = $clog2(DEPTH);

    typedef struct packed {
        logic                ok;
        logic [BYTE_W-1:0]   rbyte;
        logic                last;
        logic [OFFSET_W-1:0] wstart;
        logic [OFFSET_W-1:0] wend;
        logic [CAP_W-1:0]    avail;
        logic [CAP_W-1:0]    contig;
    } t_window_result;

    t_window_result results_due[$];

    logic [BYTE_W-1:0]   byte_mem [DEPTH];
    logic [OFFSET_W-1:0] base_off;
    logic [OFFSET_W-1:0] end_off;
    logic [OFFSET_W-1:0] start_off;
    logic [CAP_W-1:0]    cap_reg;
    int                  result_idx;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        result_idx   = 0;
    end

    function automatic logic [31:0] live_capacity();
        logic [31:0] c;
        c = {19'd0, cap_reg};
        if (c == 0) c = 32'd1;
        if (c > 32'(DEPTH)) c = 32'(DEPTH);
        return c;
    endfunction

    function automatic void queue_result(logic ok, logic [BYTE_W-1:0] b, logic last);
        t_window_result r;
        logic [31:0] cap, held, spare, to_end, contig;
        cap        = live_capacity();
        held       = end_off - start_off;
        spare      = (held >= cap) ? 32'd0 : cap - held;
        to_end     = cap - ((end_off - base_off) % cap);
        contig     = (spare < to_end) ? spare : to_end;
        r.ok       = ok;
        r.rbyte    = b;
        r.last     = last;
        r.wstart   = start_off;
        r.wend     = end_off;
        r.avail    = held[CAP_W-1:0];
        r.contig   = contig[CAP_W-1:0];
        results_due.push_back(r);
    endfunction

    function automatic void apply_command(logic [1:0] cmd, logic [31:0] off,
                                          logic [SIZE_W-1:0] sz, logic [BYTE_W-1:0] wb);
        logic [31:0] cap, held, pos;
        int unsigned k;
        cap  = live_capacity();
        held = end_off - start_off;
        case (cmd)
            CMD_APPEND: begin
                if (held >= cap) begin
                    queue_result(1'b0, '0, 1'b1);
                end else begin
                    pos = (end_off - base_off) % cap;
                    byte_mem[pos[AW-1:0]] = wb;
                    end_off = end_off + 1;
                    queue_result(1'b1, '0, 1'b1);
                end
            end
            CMD_READ: begin
                if (sz == 0) begin
                    queue_result(1'b1, '0, 1'b1);
                end else if (sz > MAX_READ || sz > cap || off < start_off || off > end_off ||
                             (end_off - off) < sz) begin
                    queue_result(1'b0, '0, 1'b1);
                end else begin
                    pos = (off - base_off) % cap;
                    for (k = 0; k < sz; k++) begin
                        queue_result(1'b1, byte_mem[pos[AW-1:0]], (k + 1) == 32'(sz));
                        pos = pos + 1;
                        if (pos >= cap) pos = 0;
                    end
                end
            end
            CMD_CONSUME: begin
                if (off > start_off) start_off = (off > end_off) ? end_off : off;
                queue_result(1'b1, '0, 1'b1);
            end
            default: begin
                base_off  = off;
                end_off   = off;
                start_off = off;
                queue_result(1'b1, '0, 1'b1);
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("result %0d: %s is %0h, expected %0h", result_idx, what, got, want);
        o_fail_count = o_fail_count + 1;
    endtask

    task automatic check_result();
        t_window_result want;
        if (results_due.size() == 0) begin
            report_mismatch("unexpected result", 32'd1, 32'd0);
        end else begin
            want = results_due.pop_front();
            if (i_ok !== want.ok) report_mismatch("ok", 32'(i_ok), 32'(want.ok));
            if (i_read_byte !== want.rbyte)
                report_mismatch("read_byte", 32'(i_read_byte), 32'(want.rbyte));
            if (i_last !== want.last) report_mismatch("last", 32'(i_last), 32'(want.last));
            if (i_window_start !== want.wstart)
                report_mismatch("window_start", i_window_start, want.wstart);
            if (i_window_end !== want.wend)
                report_mismatch("window_end", i_window_end, want.wend);
            if (i_available !== want.avail)
                report_mismatch("available", 32'(i_available), 32'(want.avail));
            if (i_contiguous_free !== want.contig)
                report_mismatch("contiguous_free", 32'(i_contiguous_free), 32'(want.contig));
        end
        result_idx = result_idx + 1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            base_off  = '0;
            end_off   = '0;
            start_off = '0;
            cap_reg   = CAP_RESET;
            results_due.delete();
        end else begin
            if (i_valid === 1'b1) check_result();
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_CAP)
                cap_reg = i_pwdata[CAP_W-1:0];
            if (i_start && i_busy === 1'b0)
                apply_command(i_cmd, i_offset, i_size, i_write_byte);
        end
        o_pending <= results_due.size();
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// top of the offset window ring buffer bench: clock, reset, apb writes and command stimulus
// depends on owrb_pkg, offset_window_ring_buffer and owrb_checker

module testbench;
    import owrb_pkg::*;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [APB_AW-1:0]   paddr        = '0;
    logic [APB_DW-1:0]   pwdata       = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                start        = 1'b0;
    logic                busy;
    logic [1:0]          i_cmd        = CMD_APPEND;
    logic [OFFSET_W-1:0] i_offset     = '0;
    logic [SIZE_W-1:0]   i_size       = '0;
    logic [BYTE_W-1:0]   i_write_byte = '0;
    logic                o_valid;
    logic                o_ok;
    logic [BYTE_W-1:0]   o_read_byte;
    logic                o_last;
    logic [OFFSET_W-1:0] o_window_start;
    logic [OFFSET_W-1:0] o_window_end;
    logic [CAP_W-1:0]    o_available;
    logic [CAP_W-1:0]    o_contiguous_free;
    int                  fail_count;
    int                  pending;

    logic [31:0] s_start, s_end, s_cap;
    bit          no_gaps;

    always #2 i_clk = ~i_clk;

    offset_window_ring_buffer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .start             (start),
        .busy              (busy),
        .i_cmd             (i_cmd),
        .i_offset          (i_offset),
        .i_size            (i_size),
        .i_write_byte      (i_write_byte),
        .o_valid           (o_valid),
        .o_ok              (o_ok),
        .o_read_byte       (o_read_byte),
        .o_last            (o_last),
        .o_window_start    (o_window_start),
        .o_window_end      (o_window_end),
        .o_available       (o_available),
        .o_contiguous_free (o_contiguous_free)
    );

    owrb_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_pready          (pready),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .i_start           (start),
        .i_busy            (busy),
        .i_cmd             (i_cmd),
        .i_offset          (i_offset),
        .i_size            (i_size),
        .i_write_byte      (i_write_byte),
        .i_valid           (o_valid),
        .i_ok              (o_ok),
        .i_read_byte       (o_read_byte),
        .i_last            (o_last),
        .i_window_start    (o_window_start),
        .i_window_end      (o_window_end),
        .i_available       (o_available),
        .i_contiguous_free (o_contiguous_free),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(logic [1:0] cmd, logic [31:0] off, logic [SIZE_W-1:0] sz,
                             logic [BYTE_W-1:0] wb);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_cmd        <= cmd;
        i_offset     <= off;
        i_size       <= sz;
        i_write_byte <= wb;
        do @(negedge i_clk); while (busy !== 1'b0);
        @(posedge i_clk);
        case (cmd)
            CMD_APPEND:  if (s_end - s_start < s_cap) s_end = s_end + 1;
            CMD_CONSUME: if (off > s_start) s_start = (off > s_end) ? s_end : off;
            CMD_REWIND: begin
                s_start = off;
                s_end   = off;
            end
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0 || busy !== 1'b0);
    endtask

    task automatic cfg_write(logic [31:0] value);
        wait_idle();
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_CAP;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        s_cap = {19'd0, value[CAP_W-1:0]};
        if (s_cap == 0) s_cap = 1;
        if (s_cap > DEPTH_DEF) s_cap = DEPTH_DEF;
    endtask

    task automatic rand_item();
        int r;
        logic [31:0] held, nmax, off, noise_off;
        logic [1:0] noise_cmd;
        logic [SIZE_W-1:0] sz;
        logic [BYTE_W-1:0] wb;
        r         = $urandom_range(0, 99);
        held      = s_end - s_start;
        wb        = BYTE_W'($urandom);
        noise_cmd = 2'($urandom_range(0, 3));
        noise_off = $urandom;
        if (r < 8) begin
            sz = SIZE_W'($urandom_range(0, 127));
            send_item(noise_cmd, noise_off, sz, wb);
        end else if (r < 52 || held == 0) begin
            send_item(CMD_APPEND, noise_off, 7'd0, wb);
        end else if (r < 82) begin
            nmax = held;
            if (nmax > MAX_READ_DEF) nmax = MAX_READ_DEF;
            if (nmax > s_cap) nmax = s_cap;
            if ($urandom_range(0, 9) == 0) begin
                off = s_start + $urandom_range(0, held);
                sz  = SIZE_W'($urandom_range(1, 64));
            end else begin
                sz  = ($urandom_range(0, 4) == 0) ? SIZE_W'(nmax) :
                                                    SIZE_W'($urandom_range(1, nmax));
                off = s_start + $urandom_range(0, held - sz);
            end
            send_item(CMD_READ, off, sz, wb);
        end else if (r < 97) begin
            off = ($urandom_range(0, 9) == 0) ? s_start - 1 : s_start + $urandom_range(0, held + 2);
            send_item(CMD_CONSUME, off, 7'd0, wb);
        end else begin
            send_item(CMD_REWIND, noise_off, 7'd0, wb);
        end
    endtask

    logic [31:0] cap_settings[7] = '{32'd16, 32'd1, 32'd4096, 32'd0, 32'd37,
                                     32'h0000_3FFF, 32'hFFFF_E064};

    initial begin
        int n, p;
        logic [31:0] rw;
        s_start = 0;
        s_end   = 0;
        s_cap   = DEPTH_DEF;
        no_gaps = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(CMD_READ,    32'd0,         7'd0,   8'h00);
        send_item(CMD_APPEND,  32'd0,         7'd0,   8'h00);
        send_item(CMD_APPEND,  32'hFFFF_FFFF, 7'd127, 8'hFF);
        send_item(CMD_APPEND,  32'd0,         7'd0,   8'hA5);
        send_item(CMD_READ,    32'd0,         7'd3,   8'h00);
        send_item(CMD_READ,    32'd1,         7'd2,   8'h00);
        send_item(CMD_READ,    32'd0,         7'd4,   8'h00);
        send_item(CMD_READ,    32'd0,         7'd65,  8'h00);
        send_item(CMD_READ,    32'd0,         7'd127, 8'h00);
        send_item(CMD_CONSUME, 32'd1,         7'd0,   8'h00);
        send_item(CMD_READ,    32'd0,         7'd1,   8'h00);
        send_item(CMD_READ,    32'd4,         7'd1,   8'h00);
        send_item(CMD_CONSUME, 32'd0,         7'd0,   8'h00);
        send_item(CMD_CONSUME, 32'hFFFF_FFFF, 7'd0,   8'h00);
        send_item(CMD_REWIND,  32'hFFFF_FFFE, 7'd0,   8'h00);
        send_item(CMD_APPEND,  32'd0,         7'd0,   8'h5A);
        send_item(CMD_APPEND,  32'd0,         7'd0,   8'hC3);
        send_item(CMD_APPEND,  32'd0,         7'd0,   8'h3C);
        send_item(CMD_READ,    32'hFFFF_FFFE, 7'd3,   8'h00);
        send_item(CMD_READ,    32'd0,         7'd1,   8'h00);
        send_item(CMD_READ,    32'd1,         7'd0,   8'h00);
        send_item(CMD_REWIND,  32'd0,         7'd0,   8'h00);

        for (p = 0; p < 7; p++) begin
            cfg_write(cap_settings[p]);
            no_gaps = ($urandom_range(0, 3) == 0);
            rw = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 40) : $urandom;
            send_item(CMD_REWIND, rw, 7'd0, 8'h00);
            for (n = 0; n < 52; n++) rand_item();
        end

        // shrink capacity below the held count; reads are then only rejected or empty
        cfg_write(32'd37);
        no_gaps = 1'b0;
        send_item(CMD_REWIND, 32'h8000_0000, 7'd0, 8'h00);
        for (n = 0; n < 30; n++) send_item(CMD_APPEND, 32'd0, 7'd0, BYTE_W'($urandom));
        cfg_write(32'd16);
        send_item(CMD_APPEND,  32'd0,          7'd0,  8'h77);
        send_item(CMD_READ,    s_start,        7'd0,  8'h00);
        send_item(CMD_READ,    s_start,        7'd20, 8'h00);
        send_item(CMD_READ,    s_start - 1,    7'd4,  8'h00);
        send_item(CMD_CONSUME, s_start + 20,   7'd0,  8'h00);
        send_item(CMD_APPEND,  32'd0,          7'd0,  8'h11);
        send_item(CMD_APPEND,  32'd0,          7'd0,  8'h22);
        send_item(CMD_REWIND,  $urandom,       7'd0,  8'h00);

        cfg_write(32'd4096);
        send_item(CMD_REWIND, $urandom, 7'd0, 8'h00);
        for (n = 0; n < 40; n++) rand_item();

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
